// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the angle and bias filter.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define KAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define KAB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/kab_pkg.sv -----
// Shared types, operation codes, register codes and the step program of the filter.
// No dependencies; used by the controller, the datapath and the top level.
package kab_pkg;

  typedef struct packed {
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_rate;
  } kab_in_t;

  typedef struct packed {
    logic signed [31:0] filtered_angle;
    logic signed [31:0] corrected_rate;
    logic signed [31:0] bias_estimate;
  } kab_out_t;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [4:0] R_ANG  = 5'd0;
  localparam logic [4:0] R_BIAS = 5'd1;
  localparam logic [4:0] R_P00  = 5'd2;
  localparam logic [4:0] R_P01  = 5'd3;
  localparam logic [4:0] R_P10  = 5'd4;
  localparam logic [4:0] R_P11  = 5'd5;
  localparam logic [4:0] R_MA   = 5'd6;
  localparam logic [4:0] R_MR   = 5'd7;
  localparam logic [4:0] R_ERR  = 5'd8;
  localparam logic [4:0] R_D0   = 5'd9;
  localparam logic [4:0] R_D1   = 5'd10;
  localparam logic [4:0] R_PCT0 = 5'd11;
  localparam logic [4:0] R_PCT1 = 5'd12;
  localparam logic [4:0] R_E    = 5'd13;
  localparam logic [4:0] R_K0   = 5'd14;
  localparam logic [4:0] R_K1   = 5'd15;
  localparam logic [4:0] R_T1   = 5'd16;
  localparam logic [4:0] R_TMP  = 5'd17;
  localparam logic [4:0] R_DT   = 5'd18;
  localparam logic [4:0] R_QA   = 5'd19;
  localparam logic [4:0] R_QB   = 5'd20;
  localparam logic [4:0] R_RM   = 5'd21;
  localparam logic [4:0] R_C    = 5'd22;
  localparam logic [4:0] R_ZERO = 5'd23;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DT = 3'd0;
  localparam logic [2:0] CFG_QA = 3'd1;
  localparam logic [2:0] CFG_QB = 3'd2;
  localparam logic [2:0] CFG_RM = 3'd3;
  localparam logic [2:0] CFG_C  = 3'd4;

  localparam logic signed [31:0] ONE_Q20 = 32'sd1048576;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] dst;
    logic [4:0] a;
    logic [4:0] b;
  } kab_uop_t;

  typedef struct packed {
    logic     go;
    logic     load_in;
    kab_uop_t uop;
  } kab_cmd_t;

  typedef struct packed {
    logic done;
  } kab_sts_t;

  localparam logic [5:0] LAST_PC = 6'd33;

  function automatic kab_uop_t mk(input logic [1:0] op, input logic [4:0] dst,
                                  input logic [4:0] a, input logic [4:0] b);
    kab_uop_t u;
    u.op = op; u.dst = dst; u.a = a; u.b = b;
    return u;
  endfunction

  // One filter step as a list of saturating operations.
  function automatic kab_uop_t ucode(input logic [5:0] pc);
    kab_uop_t u;
    unique case (pc)
      6'd0:  u = mk(OP_SUB, R_TMP,  R_MR,   R_BIAS);
      6'd1:  u = mk(OP_MUL, R_TMP,  R_TMP,  R_DT);
      6'd2:  u = mk(OP_ADD, R_ANG,  R_ANG,  R_TMP);
      6'd3:  u = mk(OP_SUB, R_ERR,  R_MA,   R_ANG);
      6'd4:  u = mk(OP_SUB, R_D0,   R_QA,   R_P01);
      6'd5:  u = mk(OP_SUB, R_D0,   R_D0,   R_P10);
      6'd6:  u = mk(OP_SUB, R_D1,   R_ZERO, R_P11);
      6'd7:  u = mk(OP_MUL, R_TMP,  R_D0,   R_DT);
      6'd8:  u = mk(OP_ADD, R_P00,  R_P00,  R_TMP);
      6'd9:  u = mk(OP_MUL, R_TMP,  R_D1,   R_DT);
      6'd10: u = mk(OP_ADD, R_P01,  R_P01,  R_TMP);
      6'd11: u = mk(OP_ADD, R_P10,  R_P10,  R_TMP);
      6'd12: u = mk(OP_MUL, R_TMP,  R_QB,   R_DT);
      6'd13: u = mk(OP_ADD, R_P11,  R_P11,  R_TMP);
      6'd14: u = mk(OP_MUL, R_PCT0, R_C,    R_P00);
      6'd15: u = mk(OP_MUL, R_PCT1, R_C,    R_P10);
      6'd16: u = mk(OP_MUL, R_TMP,  R_C,    R_PCT0);
      6'd17: u = mk(OP_ADD, R_E,    R_RM,   R_TMP);
      6'd18: u = mk(OP_DIV, R_K0,   R_PCT0, R_E);
      6'd19: u = mk(OP_DIV, R_K1,   R_PCT1, R_E);
      6'd20: u = mk(OP_MUL, R_T1,   R_C,    R_P01);
      6'd21: u = mk(OP_MUL, R_TMP,  R_K0,   R_PCT0);
      6'd22: u = mk(OP_SUB, R_P00,  R_P00,  R_TMP);
      6'd23: u = mk(OP_MUL, R_TMP,  R_K0,   R_T1);
      6'd24: u = mk(OP_SUB, R_P01,  R_P01,  R_TMP);
      6'd25: u = mk(OP_MUL, R_TMP,  R_K1,   R_PCT0);
      6'd26: u = mk(OP_SUB, R_P10,  R_P10,  R_TMP);
      6'd27: u = mk(OP_MUL, R_TMP,  R_K1,   R_T1);
      6'd28: u = mk(OP_SUB, R_P11,  R_P11,  R_TMP);
      6'd29: u = mk(OP_MUL, R_TMP,  R_K0,   R_ERR);
      6'd30: u = mk(OP_ADD, R_ANG,  R_ANG,  R_TMP);
      6'd31: u = mk(OP_MUL, R_TMP,  R_K1,   R_ERR);
      6'd32: u = mk(OP_ADD, R_BIAS, R_BIAS, R_TMP);
      6'd33: u = mk(OP_SUB, R_TMP,  R_MR,   R_BIAS);
      default: u = mk(OP_SUB, R_TMP, R_MR, R_BIAS);
    endcase
    return u;
  endfunction

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh000000007FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -64'sh0000000080000000) r = -32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- src/kab_ctl.sv -----
// Sequencer of the filter: steps through the operation list, one operation at a time.
// Depends on kab_pkg.
module kab_ctl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             out_free,
  input  kab_pkg::kab_sts_t sts,
  output kab_pkg::kab_cmd_t cmd,
  output logic             in_ready,
  output logic             load_out
);
  import kab_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [5:0] pc_r, pc_nxt;

  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    cmd.go      = 1'b0;
    cmd.load_in = 1'b0;
    cmd.uop     = ucode(pc_r);
    load_out    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_in = 1'b1;
          pc_nxt      = '0;
          state_nxt   = S_RUN;
        end
      end
      S_RUN: begin
        cmd.go    = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sts.done) begin
          if (pc_r == LAST_PC) begin
            state_nxt = S_FIN;
          end else begin
            pc_nxt    = pc_r + 6'd1;
            state_nxt = S_RUN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end
endmodule

// ----- src/kab_dp.sv -----
// Datapath of the filter: state and scratch registers, a shared saturating adder,
// a registered 32x32 multiplier and a bit-serial divider. Depends on kab_pkg.
module kab_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  kab_pkg::kab_cmd_t   cmd,
  input  kab_pkg::kab_in_t    in_data,
  input  logic [30:0]         time_step,
  input  logic [30:0]         angle_process_noise,
  input  logic [30:0]         bias_process_noise,
  input  logic [30:0]         measurement_noise,
  input  logic signed [31:0]  observation_gain,
  output kab_pkg::kab_sts_t   sts,
  output kab_pkg::kab_out_t   result
);
  import kab_pkg::*;

  localparam int DIV_BITS = 52;

  logic signed [31:0] ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [31:0] ma_r, mr_r, err_r, d0_r, d1_r, pct0_r, pct1_r;
  logic signed [31:0] e_r, k0_r, k1_r, t1_r, tmp_r;

  logic signed [31:0] opa, opb;

  function automatic logic signed [31:0] rd(
    input logic [4:0] sel, input logic signed [31:0] a0, input logic signed [31:0] a1,
    input logic signed [31:0] a2, input logic signed [31:0] a3,
    input logic signed [31:0] a4, input logic signed [31:0] a5,
    input logic signed [31:0] a6, input logic signed [31:0] a7,
    input logic signed [31:0] a8, input logic signed [31:0] a9,
    input logic signed [31:0] a10, input logic signed [31:0] a11,
    input logic signed [31:0] a12, input logic signed [31:0] a13,
    input logic signed [31:0] a14, input logic signed [31:0] a15,
    input logic signed [31:0] a16, input logic signed [31:0] a17,
    input logic signed [31:0] a18, input logic signed [31:0] a19,
    input logic signed [31:0] a20, input logic signed [31:0] a21,
    input logic signed [31:0] a22);
    logic signed [31:0] v;
    unique case (sel)
      R_ANG:  v = a0;   R_BIAS: v = a1;   R_P00:  v = a2;   R_P01:  v = a3;
      R_P10:  v = a4;   R_P11:  v = a5;   R_MA:   v = a6;   R_MR:   v = a7;
      R_ERR:  v = a8;   R_D0:   v = a9;   R_D1:   v = a10;  R_PCT0: v = a11;
      R_PCT1: v = a12;  R_E:    v = a13;  R_K0:   v = a14;  R_K1:   v = a15;
      R_T1:   v = a16;  R_TMP:  v = a17;  R_DT:   v = a18;  R_QA:   v = a19;
      R_QB:   v = a20;  R_RM:   v = a21;  R_C:    v = a22;
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = rd(cmd.uop.a, ang_r, bias_r, p00_r, p01_r, p10_r, p11_r, ma_r, mr_r, err_r,
             d0_r, d1_r, pct0_r, pct1_r, e_r, k0_r, k1_r, t1_r, tmp_r,
             {1'b0, time_step}, {1'b0, angle_process_noise}, {1'b0, bias_process_noise},
             {1'b0, measurement_noise}, observation_gain);
    opb = rd(cmd.uop.b, ang_r, bias_r, p00_r, p01_r, p10_r, p11_r, ma_r, mr_r, err_r,
             d0_r, d1_r, pct0_r, pct1_r, e_r, k0_r, k1_r, t1_r, tmp_r,
             {1'b0, time_step}, {1'b0, angle_process_noise}, {1'b0, bias_process_noise},
             {1'b0, measurement_noise}, observation_gain);
  end

  // Adder.
  logic signed [32:0] alu_sum;
  logic signed [31:0] alu_val;
  logic               alu_go;
  assign alu_sum = (cmd.uop.op == OP_SUB) ? (33'(opa) - 33'(opb)) : (33'(opa) + 33'(opb));
  assign alu_val = sat64(64'(alu_sum));
  assign alu_go  = cmd.go && (cmd.uop.op == OP_ADD || cmd.uop.op == OP_SUB);

  // Multiplier: product registered, rounding and saturation in the next cycle.
  logic signed [63:0] prod_r;
  logic               mul_pend_r;
  logic [4:0]         dst_r;
  logic signed [63:0] mul_rnd;
  logic signed [31:0] mul_val;
  assign mul_rnd = (prod_r + 64'sd524288) >>> 20;
  assign mul_val = sat64(mul_rnd);

  // Divider: restoring, one quotient bit per cycle on magnitudes.
  logic                div_act_r, div_neg_r, div_zero_r;
  logic [5:0]          div_cnt_r;
  logic [DIV_BITS-1:0] div_n_r, div_q_r;
  logic [31:0]         div_rem_r, div_d_r;
  logic [32:0]         rem_sh;
  logic                rem_ge;
  logic [32:0]         rem_sub;
  logic signed [52:0]  div_qs;
  logic signed [31:0]  div_val;
  logic                div_fin;
  logic [31:0]         abs_a, abs_b;

  assign abs_a   = opa[31] ? (32'd0 - opa) : opa;
  assign abs_b   = opb[31] ? (32'd0 - opb) : opb;
  assign rem_sh  = {div_rem_r, div_n_r[DIV_BITS-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_d_r};
  assign rem_sub = rem_sh - {1'b0, div_d_r};
  assign div_qs  = div_neg_r ? -$signed({1'b0, div_q_r}) : $signed({1'b0, div_q_r});
  assign div_val = div_zero_r ? 32'sd0 : sat64({{11{div_qs[52]}}, div_qs});
  assign div_fin = div_act_r && (div_cnt_r == '0);

  // Single write port.
  logic               wr_en;
  logic [4:0]         wr_dst;
  logic signed [31:0] wr_val;
  always_comb begin
    wr_en  = 1'b0;
    wr_dst = dst_r;
    wr_val = mul_val;
    priority if (alu_go) begin
      wr_en = 1'b1; wr_dst = cmd.uop.dst; wr_val = alu_val;
    end else if (mul_pend_r) begin
      wr_en = 1'b1;
    end else if (div_fin) begin
      wr_en = 1'b1; wr_val = div_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r  <= '0;
      bias_r <= '0;
      p00_r  <= ONE_Q20;
      p01_r  <= '0;
      p10_r  <= '0;
      p11_r  <= ONE_Q20;
    end else if (wr_en) begin
      unique case (wr_dst)
        R_ANG:  ang_r  <= wr_val;
        R_BIAS: bias_r <= wr_val;
        R_P00:  p00_r  <= wr_val;
        R_P01:  p01_r  <= wr_val;
        R_P10:  p10_r  <= wr_val;
        R_P11:  p11_r  <= wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ma_r <= in_data.measured_angle;
      mr_r <= in_data.measured_rate;
    end
    if (wr_en) begin
      unique case (wr_dst)
        R_ERR:  err_r  <= wr_val;
        R_D0:   d0_r   <= wr_val;
        R_D1:   d1_r   <= wr_val;
        R_PCT0: pct0_r <= wr_val;
        R_PCT1: pct1_r <= wr_val;
        R_E:    e_r    <= wr_val;
        R_K0:   k0_r   <= wr_val;
        R_K1:   k1_r   <= wr_val;
        R_T1:   t1_r   <= wr_val;
        R_TMP:  tmp_r  <= wr_val;
        default: ;
      endcase
    end
    if (cmd.go) begin
      dst_r <= cmd.uop.dst;
    end
    if (cmd.go && cmd.uop.op == OP_MUL) begin
      prod_r <= 64'(opa) * 64'(opb);
    end
    if (cmd.go && cmd.uop.op == OP_DIV) begin
      div_n_r    <= {abs_a, 20'd0};
      div_d_r    <= abs_b;
      div_rem_r  <= '0;
      div_q_r    <= '0;
      div_neg_r  <= opa[31] ^ opb[31];
      div_zero_r <= (opb == 32'sd0);
    end else if (div_act_r && div_cnt_r != '0) begin
      div_n_r   <= {div_n_r[DIV_BITS-2:0], 1'b0};
      div_rem_r <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
      div_q_r   <= {div_q_r[DIV_BITS-2:0], rem_ge};
    end
  end

  logic done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_pend_r <= 1'b0;
      div_act_r  <= 1'b0;
      div_cnt_r  <= '0;
      done_r     <= 1'b0;
    end else begin
      mul_pend_r <= cmd.go && (cmd.uop.op == OP_MUL);
      done_r     <= wr_en;
      if (cmd.go && cmd.uop.op == OP_DIV) begin
        div_act_r <= 1'b1;
        div_cnt_r <= 6'(DIV_BITS);
      end else if (div_fin) begin
        div_act_r <= 1'b0;
      end else if (div_act_r) begin
        div_cnt_r <= div_cnt_r - 6'd1;
      end
    end
  end

  assign sts.done              = done_r;
  assign result.filtered_angle = ang_r;
  assign result.corrected_rate = tmp_r;
  assign result.bias_estimate  = bias_r;
endmodule

// ----- src/kalman_angle_bias_filter.sv -----
// Two-state angle and gyro bias filter, Q12.20 fixed point, one result per item.
// A step runs 34 operations in turn (18 add/subtract steps, 14 multiplies, 2 divisions),
// then hands its result over to the output register.
// A new item is accepted only when the controller is idle, after the last result has moved to
// the output register; the multiplier is shared, the divider produces one quotient bit per cycle.
// Reset (synchronous, rst_n low): angle and bias zero, covariance identity, registers at defaults.
module kalman_angle_bias_filter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kab_pkg::kab_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kab_pkg::kab_out_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import kab_pkg::*;
`include "assert_macros.svh"

  // Configuration registers. Unsigned ones keep only their low 31 bits.
  logic [30:0]        dt_r, qa_r, qb_r, rm_r;
  logic signed [31:0] c_r;
  logic [2:0]         cfg_idx;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= 31'd5243;
      qa_r <= 31'd1049;
      qb_r <= 31'd5243;
      rm_r <= 31'd524288;
      c_r  <= ONE_Q20;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_DT: dt_r <= cfg_pwdata[30:0];
        CFG_QA: qa_r <= cfg_pwdata[30:0];
        CFG_QB: qb_r <= cfg_pwdata[30:0];
        CFG_RM: rm_r <= cfg_pwdata[30:0];
        CFG_C:  c_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_DT:  cfg_prdata = {1'b0, dt_r};
      CFG_QA:  cfg_prdata = {1'b0, qa_r};
      CFG_QB:  cfg_prdata = {1'b0, qb_r};
      CFG_RM:  cfg_prdata = {1'b0, rm_r};
      CFG_C:   cfg_prdata = c_r;
      default: cfg_prdata = '0;
    endcase
  end

  // The controller runs the operation list; the datapath holds the filter state.
  kab_cmd_t cmd;
  kab_sts_t sts;
  kab_out_t result;
  logic     load_out;
  logic     in_fire;
  logic     out_valid_r;
  kab_out_t out_data_r;

  assign in_fire = in_valid && in_ready;

  kab_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (!out_valid_r || out_ready),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready),
    .load_out (load_out)
  );

  kab_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_data             (in_data),
    .time_step           (dt_r),
    .angle_process_noise (qa_r),
    .bias_process_noise  (qb_r),
    .measurement_noise   (rm_r),
    .observation_gain    (c_r),
    .sts                 (sts),
    .result              (result)
  );

  // Output register: the finished item waits here, so the datapath can take the next
  // item while the consumer stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted item keeps the input closed while its step is computed.
  `KAB_ASSERT(a_busy_after_accept, in_fire |=> !in_ready, "input accepted while busy")
  // A result only appears when the controller has finished a step.
  `KAB_ASSERT(a_out_from_ctl, $rose(out_valid_r) |-> $past(load_out), "stray result")
  // The controller never loads a new result over one still waiting.
  `KAB_ASSERT(a_no_overwrite, load_out |-> (!out_valid_r || out_ready), "result lost")
  // No operation is issued while an item is being loaded.
  `KAB_ASSERT_ALWAYS(a_go_excl, !(cmd.go && cmd.load_in), "issue during load")
endmodule
